// ===== rtl/core/vds_pkg.sv =====
// vds_pkg: shared widths, reset values, register indexes and types for the
// speech decision smoother. No dependencies.
package vds_pkg;

    // field widths
    localparam int PROB_BITS       = 16;
    localparam int RUN_BITS        = 8;
    localparam int HANG_BITS       = 10;
    localparam int SIL_BITS        = 11;
    localparam int FRAME_OUT_BITS  = 32;
    localparam int CFG_INDEX_BITS  = 3;
    localparam int CFG_DATA_BITS   = 16;

    // default frame counter width
    localparam int FRAME_INDEX_BITS_DEF = 32;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_VOTE_THRESHOLD  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ONSET_FRAMES    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WARMUP_FRAMES   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HANGOVER_FRAMES = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HANGOVER_ALT    = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RESUME_FRAMES   = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LANGUAGE_MODE   = 3'd6;

    // register reset values
    localparam logic [PROB_BITS-1:0] VOTE_THRESHOLD_RST  = 16'd26214;
    localparam logic [RUN_BITS-1:0]  ONSET_FRAMES_RST    = 8'd12;
    localparam logic [RUN_BITS-1:0]  WARMUP_FRAMES_RST   = 8'd12;
    localparam logic [HANG_BITS-1:0] HANGOVER_FRAMES_RST = 10'd50;
    localparam logic [HANG_BITS-1:0] HANGOVER_ALT_RST    = 10'd55;
    localparam logic [RUN_BITS-1:0]  RESUME_FRAMES_RST   = 8'd8;

    typedef struct packed {
        logic [PROB_BITS-1:0] vote_threshold;
        logic [RUN_BITS-1:0]  onset_frames;
        logic [RUN_BITS-1:0]  warmup_frames;
        logic [HANG_BITS-1:0] hangover_frames;
        logic [HANG_BITS-1:0] hangover_frames_alt;
        logic [RUN_BITS-1:0]  resume_frames;
        logic                 language_mode;
    } vds_cfg_t;

    typedef struct packed {
        logic                      speech_active;
        logic                      frame_vote;
        logic                      start_event;
        logic [FRAME_OUT_BITS-1:0] start_frame;
        logic                      end_event;
        logic [FRAME_OUT_BITS-1:0] end_frame;
    } vds_result_t;

endpackage

// ===== rtl/core/vds_ifs.sv =====
// vds_ifs: valid/ready channel interfaces for probability items, result items
// and register writes. Depends on vds_pkg.
interface vds_prob_if
    import vds_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [PROB_BITS-1:0] speech_probability;

    modport source (output valid, output speech_probability, input ready);
    modport sink   (input valid, input speech_probability, output ready);
endinterface

interface vds_result_if
    import vds_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      speech_active;
    logic                      frame_vote;
    logic                      start_event;
    logic [FRAME_OUT_BITS-1:0] start_frame;
    logic                      end_event;
    logic [FRAME_OUT_BITS-1:0] end_frame;

    modport source (output valid, output speech_active, output frame_vote,
                    output start_event, output start_frame, output end_event,
                    output end_frame, input ready);
    modport sink   (input valid, input speech_active, input frame_vote,
                    input start_event, input start_frame, input end_event,
                    input end_frame, output ready);
endinterface

interface vds_cfg_if
    import vds_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/vds_cfg_regs.sv =====
// vds_cfg_regs: register file for the smoother settings, written over the
// configuration channel. Depends on vds_pkg and vds_cfg_if.
module vds_cfg_regs
    import vds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    vds_cfg_if.sink     cfg,
    output vds_cfg_t    settings
);

    vds_cfg_t cfg_reg;
    logic     wr_en;

    // writes are always taken
    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid;
    assign settings  = cfg_reg;

    // register writes, out-of-range index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.vote_threshold      <= VOTE_THRESHOLD_RST;
            cfg_reg.onset_frames        <= ONSET_FRAMES_RST;
            cfg_reg.warmup_frames       <= WARMUP_FRAMES_RST;
            cfg_reg.hangover_frames     <= HANGOVER_FRAMES_RST;
            cfg_reg.hangover_frames_alt <= HANGOVER_ALT_RST;
            cfg_reg.resume_frames       <= RESUME_FRAMES_RST;
            cfg_reg.language_mode       <= 1'b0;
        end
        else if (wr_en)
        begin
            case (cfg.index)
                CFG_VOTE_THRESHOLD:  cfg_reg.vote_threshold      <= cfg.data;
                CFG_ONSET_FRAMES:    cfg_reg.onset_frames        <= cfg.data[RUN_BITS-1:0];
                CFG_WARMUP_FRAMES:   cfg_reg.warmup_frames       <= cfg.data[RUN_BITS-1:0];
                CFG_HANGOVER_FRAMES: cfg_reg.hangover_frames     <= cfg.data[HANG_BITS-1:0];
                CFG_HANGOVER_ALT:    cfg_reg.hangover_frames_alt <= cfg.data[HANG_BITS-1:0];
                CFG_RESUME_FRAMES:   cfg_reg.resume_frames       <= cfg.data[RUN_BITS-1:0];
                CFG_LANGUAGE_MODE:   cfg_reg.language_mode       <= cfg.data[0];
                default:             ;
            endcase
        end
    end

endmodule

// ===== rtl/core/vds_decision.sv =====
// vds_decision: per-frame smoothing state and the onset, hangover and resume
// rules; gives the result of the frame in the same cycle. Depends on vds_pkg.
module vds_decision
    import vds_pkg::*;
#(
    parameter int FRAME_INDEX_BITS = FRAME_INDEX_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [PROB_BITS-1:0] prob,
    input  vds_cfg_t             settings,
    output vds_result_t          result
);

    localparam int FB = FRAME_INDEX_BITS;

    logic [FB-1:0]       frame_count_reg, frame_count_next;
    logic [RUN_BITS-1:0] votes_seen_reg, votes_seen_next;
    logic                active_reg, active_next;
    logic                ending_reg, ending_next;
    logic [SIL_BITS-1:0] silence_run_reg, silence_run_next;
    logic [RUN_BITS-1:0] resume_run_reg, resume_run_next;
    logic [RUN_BITS-1:0] onset_run_reg, onset_run_next;

    logic                vote;
    logic [RUN_BITS-1:0] votes_inc;
    logic [SIL_BITS-1:0] silence_inc;
    logic [RUN_BITS-1:0] resume_inc;
    logic [RUN_BITS-1:0] onset_inc;
    logic [HANG_BITS-1:0] hang;
    logic                start_ev;
    logic                end_ev;
    logic [FB-1:0]       start_at;
    logic [FB-1:0]       end_at;
    logic [FB+FRAME_OUT_BITS-1:0] start_ext;
    logic [FB+FRAME_OUT_BITS-1:0] end_ext;

    // vote and saturating increments
    assign vote        = prob > settings.vote_threshold;
    assign votes_inc   = (&votes_seen_reg) ? votes_seen_reg : votes_seen_reg + 1'b1;
    assign silence_inc = (&silence_run_reg) ? silence_run_reg : silence_run_reg + 1'b1;
    assign resume_inc  = (&resume_run_reg) ? resume_run_reg : resume_run_reg + 1'b1;
    assign onset_inc   = (&onset_run_reg) ? onset_run_reg : onset_run_reg + 1'b1;
    assign hang        = settings.language_mode ? settings.hangover_frames_alt
                                                : settings.hangover_frames;

    // next state for one frame
    always_comb
    begin
        logic [SIL_BITS-1:0] sil_w;
        logic [RUN_BITS-1:0] res_w;
        logic [SIL_BITS:0]   limit;

        frame_count_next = frame_count_reg + 1'b1;
        votes_seen_next  = votes_inc;
        active_next      = active_reg;
        ending_next      = ending_reg;
        silence_run_next = silence_run_reg;
        resume_run_next  = resume_run_reg;
        onset_run_next   = onset_run_reg;
        start_ev         = 1'b0;
        end_ev           = 1'b0;
        start_at         = '0;
        end_at           = '0;
        sil_w            = silence_inc;
        res_w            = '0;
        limit            = '0;

        if (active_reg)
        begin
            if (ending_reg)
            begin
                // hangover: count silence, watch for a resume run
                if (vote)
                begin
                    res_w = resume_inc;
                    if (resume_inc >= settings.resume_frames)
                    begin
                        votes_seen_next = '0;
                        ending_next     = 1'b0;
                        sil_w           = '0;
                        res_w           = '0;
                    end
                end
                silence_run_next = sil_w;
                resume_run_next  = res_w;
                limit = {2'b00, hang} + {{(SIL_BITS+1-RUN_BITS){1'b0}}, res_w};
                if ({1'b0, sil_w} >= limit)
                begin
                    active_next      = 1'b0;
                    end_ev           = 1'b1;
                    end_at           = frame_count_next - {{(FB-SIL_BITS){1'b0}}, sil_w};
                    votes_seen_next  = '0;
                    ending_next      = 1'b0;
                    silence_run_next = '0;
                    onset_run_next   = '0;
                    resume_run_next  = '0;
                end
            end
            else if (!vote)
            begin
                ending_next      = 1'b1;
                silence_run_next = silence_inc;
            end
        end
        else if (votes_inc >= settings.warmup_frames)
        begin
            // onset counting once warmed up
            if (!vote)
            begin
                onset_run_next = '0;
            end
            else if (onset_inc >= settings.onset_frames)
            begin
                active_next    = 1'b1;
                onset_run_next = '0;
                start_ev       = 1'b1;
                start_at       = frame_count_next
                               - {{(FB-RUN_BITS){1'b0}}, settings.onset_frames};
            end
            else
            begin
                onset_run_next = onset_inc;
            end
        end
    end

    // frame indices to the fixed output width
    assign start_ext = {{FRAME_OUT_BITS{1'b0}}, start_at};
    assign end_ext   = {{FRAME_OUT_BITS{1'b0}}, end_at};

    assign result.speech_active = active_next;
    assign result.frame_vote    = vote;
    assign result.start_event   = start_ev;
    assign result.start_frame   = start_ext[FRAME_OUT_BITS-1:0];
    assign result.end_event     = end_ev;
    assign result.end_frame     = end_ext[FRAME_OUT_BITS-1:0];

    // state registers, updated once per processed frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= '0;
            votes_seen_reg  <= '0;
            active_reg      <= 1'b0;
            ending_reg      <= 1'b0;
            silence_run_reg <= '0;
            resume_run_reg  <= '0;
            onset_run_reg   <= '0;
        end
        else if (step)
        begin
            frame_count_reg <= frame_count_next;
            votes_seen_reg  <= votes_seen_next;
            active_reg      <= active_next;
            ending_reg      <= ending_next;
            silence_run_reg <= silence_run_next;
            resume_run_reg  <= resume_run_next;
            onset_run_reg   <= onset_run_next;
        end
    end

endmodule

// ===== rtl/core/vad_decision_smoother_top.sv =====
// vad_decision_smoother_top: input register, decision logic and result
// register of the speech decision smoother.
// Depends on vds_pkg, vds_ifs, vds_cfg_regs and vds_decision.
//
// Usage:
//   prob   - one speech probability item per frame (unsigned Q0.16)
//   result - one result item per frame: smoothed state, raw vote, start and
//            end events with their frame indices (zero when no event)
//   cfg    - register writes (index, data), always ready; write only while
//            no item is in flight
// Timing: an accepted item is captured in the input register and moves into
// the result register once that register is free; while the receiver stalls
// a full result register, the item waits in the input register.
// Throughput: one item per cycle while the receiver takes results; the state
// update of a frame is combinational between the two registers.
// Reset clears the frame counter, the run counters and the flags, and loads
// the default register values. When the receiver stalls, the result register
// holds its item and the input register still takes one more item; after
// that ready drops until the result is taken.
module vad_decision_smoother_top
    import vds_pkg::*;
#(
    parameter int FRAME_INDEX_BITS = FRAME_INDEX_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    vds_prob_if.sink      prob,
    vds_result_if.source  result,
    vds_cfg_if.sink       cfg
);

    vds_cfg_t             settings;
    vds_result_t          dec_result;
    vds_result_t          out_data_reg;
    logic                 s1_valid_reg, s1_valid_next;
    logic [PROB_BITS-1:0] s1_prob_reg;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_free;
    logic                 s1_advance;
    logic                 in_fire;

    vds_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .settings (settings)
    );

    vds_decision #(
        .FRAME_INDEX_BITS (FRAME_INDEX_BITS)
    ) u_decision (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (s1_advance),
        .prob     (s1_prob_reg),
        .settings (settings),
        .result   (dec_result)
    );

    // handshake between the two register stages
    assign out_free       = !out_valid_reg || result.ready;
    assign s1_advance     = s1_valid_reg && out_free;
    assign prob.ready     = !s1_valid_reg || s1_advance;
    assign in_fire        = prob.valid && prob.ready;
    assign s1_valid_next  = in_fire || (s1_valid_reg && !s1_advance);
    assign out_valid_next = s1_advance || (out_valid_reg && !result.ready);

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_prob_reg <= prob.speech_probability;
        end
        if (s1_advance)
        begin
            out_data_reg <= dec_result;
        end
    end

    // result channel
    assign result.valid         = out_valid_reg;
    assign result.speech_active = out_data_reg.speech_active;
    assign result.frame_vote    = out_data_reg.frame_vote;
    assign result.start_event   = out_data_reg.start_event;
    assign result.start_frame   = out_data_reg.start_frame;
    assign result.end_event     = out_data_reg.end_event;
    assign result.end_frame     = out_data_reg.end_frame;

    // a frame never both starts and ends speech
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg.start_event && out_data_reg.end_event))
        else $error("start and end event on the same item");

    // events agree with the smoothed state
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.start_event) |-> out_data_reg.speech_active)
        else $error("start event without active speech");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.end_event) |-> !out_data_reg.speech_active)
        else $error("end event with active speech");

    // a waiting input item is held until it moves on
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_advance) |=> (s1_valid_reg && $stable(s1_prob_reg)))
        else $error("input register lost a waiting item");

endmodule

// ===== dv/testbench.sv =====
// testbench: self-checking bench for vad_decision_smoother_top; predicts each
// frame result from its own copy of the smoothing state and compares fields.
// Depends on vds_pkg, vds_ifs and the top level of the block.
module testbench;
    import vds_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int IDLE_PCT       = 16;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int MAX_PRINTED    = 30;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED_INDEX = 3'd7;

    logic clk;
    logic rst_n;

    vds_prob_if   prob_ch ();
    vds_result_if res_ch ();
    vds_cfg_if    cfg_ch ();

    vad_decision_smoother_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .prob   (prob_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    // register copy and smoothing state
    vds_cfg_t                  cfg_shadow;
    logic [FRAME_OUT_BITS-1:0] frame_no;
    logic [RUN_BITS-1:0]       votes_seen;
    logic                      in_speech;
    logic                      in_hangover;
    logic [SIL_BITS-1:0]       silence_run;
    logic [RUN_BITS-1:0]       resume_run;
    logic [RUN_BITS-1:0]       onset_run;

    vds_result_t pending_decisions[$];

    int idle_pct = IDLE_PCT;
    int hold_cycles = 0;
    int error_count = 0;
    int frames_sent = 0;
    int results_checked = 0;
    int starts_seen = 0;
    int ends_seen = 0;
    int reg_writes = 0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // run limit
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("timeout after %0d cycles, %0d results outstanding", TIMEOUT_CYCLES,
                 pending_decisions.size());
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
                                      results_checked, name, got, want));
    endtask

    // one frame of the smoother: updates the state copy, returns the result
    function automatic vds_result_t smooth_frame(input logic [PROB_BITS-1:0] p);
        vds_result_t r;
        logic        vote;
        int          hang_len;
        r = '0;
        vote = p > cfg_shadow.vote_threshold;
        votes_seen = (votes_seen == '1) ? votes_seen : votes_seen + 1'b1;
        frame_no = frame_no + 1'b1;
        if (in_speech)
        begin
            if (in_hangover)
            begin
                hang_len = cfg_shadow.language_mode ? int'(cfg_shadow.hangover_frames_alt)
                                                    : int'(cfg_shadow.hangover_frames);
                silence_run = (silence_run == '1) ? silence_run : silence_run + 1'b1;
                if (vote)
                begin
                    resume_run = (resume_run == '1) ? resume_run : resume_run + 1'b1;
                    // enough talk inside hangover cancels the pending end
                    if (resume_run >= cfg_shadow.resume_frames)
                    begin
                        votes_seen = '0;
                        in_hangover = 1'b0;
                        silence_run = '0;
                        resume_run = '0;
                    end
                end
                else
                    resume_run = '0;
                // end test also runs right after a resume clear
                if (int'(silence_run) >= hang_len + int'(resume_run))
                begin
                    in_speech = 1'b0;
                    r.end_event = 1'b1;
                    r.end_frame = frame_no - FRAME_OUT_BITS'(silence_run);
                    votes_seen = '0;
                    in_hangover = 1'b0;
                    silence_run = '0;
                    onset_run = '0;
                    resume_run = '0;
                end
            end
            else if (!vote)
            begin
                in_hangover = 1'b1;
                silence_run = (silence_run == '1) ? silence_run : silence_run + 1'b1;
            end
        end
        else if (votes_seen >= cfg_shadow.warmup_frames)
        begin
            if (!vote)
                onset_run = '0;
            else
            begin
                onset_run = (onset_run == '1) ? onset_run : onset_run + 1'b1;
                if (onset_run >= cfg_shadow.onset_frames)
                begin
                    in_speech = 1'b1;
                    onset_run = '0;
                    r.start_event = 1'b1;
                    r.start_frame = frame_no - FRAME_OUT_BITS'(cfg_shadow.onset_frames);
                end
            end
        end
        r.speech_active = in_speech;
        r.frame_vote = vote;
        return r;
    endfunction

    // probabilities on either side of the current threshold
    function automatic logic [PROB_BITS-1:0] speech_prob();
        if (cfg_shadow.vote_threshold == '1)
            return '1;
        return PROB_BITS'($urandom_range(65535, int'(cfg_shadow.vote_threshold) + 1));
    endfunction

    function automatic logic [PROB_BITS-1:0] silence_prob();
        return PROB_BITS'($urandom_range(int'(cfg_shadow.vote_threshold), 0));
    endfunction

    // send one frame; called at a falling edge, returns at a falling edge
    // with valid still high so back-to-back frames are offered without a gap
    task automatic send_frame(input logic [PROB_BITS-1:0] p);
        vds_result_t r;
        if ($urandom_range(99) < idle_pct)
        begin
            prob_ch.valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        prob_ch.valid <= 1'b1;
        prob_ch.speech_probability <= p;
        do
            @(posedge clk);
        while (!prob_ch.ready);
        r = smooth_frame(p);
        @(negedge clk);
        pending_decisions.push_back(r);
        frames_sent++;
    endtask

    // stop offering frames and wait until every result is back
    task automatic wait_drained();
        prob_ch.valid <= 1'b0;
        while (pending_decisions.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        // values are masked to the register width, unknown indexes dropped
        case (idx)
            CFG_VOTE_THRESHOLD:  cfg_shadow.vote_threshold = val;
            CFG_ONSET_FRAMES:    cfg_shadow.onset_frames = val[RUN_BITS-1:0];
            CFG_WARMUP_FRAMES:   cfg_shadow.warmup_frames = val[RUN_BITS-1:0];
            CFG_HANGOVER_FRAMES: cfg_shadow.hangover_frames = val[HANG_BITS-1:0];
            CFG_HANGOVER_ALT:    cfg_shadow.hangover_frames_alt = val[HANG_BITS-1:0];
            CFG_RESUME_FRAMES:   cfg_shadow.resume_frames = val[RUN_BITS-1:0];
            CFG_LANGUAGE_MODE:   cfg_shadow.language_mode = val[0];
            default: ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    // alternating talk and silence runs with some boundary and noise frames
    task automatic send_bursts(input int n_frames, input int max_run);
        int run_len;
        int sent;
        bit talking;
        sent = 0;
        talking = 1'($urandom_range(1));
        while (sent < n_frames)
        begin
            run_len = $urandom_range(max_run, 1);
            for (int k = 0; k < run_len && sent < n_frames; k++)
            begin
                case ($urandom_range(19))
                    0:       send_frame(cfg_shadow.vote_threshold);
                    1, 2:    send_frame(PROB_BITS'($urandom));
                    default: send_frame(talking ? speech_prob() : silence_prob());
                endcase
                sent++;
            end
            talking = !talking;
        end
    endtask

    // reset values: threshold boundary, warmup not yet reached
    task automatic test_threshold_edges();
        send_frame(16'h0000);
        send_frame(16'hFFFF);
        send_frame(VOTE_THRESHOLD_RST);
        send_frame(VOTE_THRESHOLD_RST + 1'b1);
        send_frame(16'h0000);
        send_frame(16'hFFFF);
    endtask

    // zero onset, resume and hangover; junk upper bits and an unknown index
    task automatic test_zero_lengths();
        wait_drained();
        write_reg(CFG_VOTE_THRESHOLD, 16'h8000);
        write_reg(CFG_ONSET_FRAMES, 16'hFF00);
        write_reg(CFG_WARMUP_FRAMES, 16'h0301);
        write_reg(CFG_RESUME_FRAMES, 16'h2A00);
        write_reg(CFG_HANGOVER_FRAMES, 16'hFC00);
        write_reg(CFG_UNUSED_INDEX, 16'h0001);
        write_reg(CFG_LANGUAGE_MODE, 16'hFFFE);
        send_frame(16'hFFFF);
        send_frame(16'h0000);
        send_frame(16'hFFFF);
        send_frame(16'h8000);
        send_frame(16'h8001);
    endtask

    // alternate hangover: resume cancels the end, then silence ends speech
    task automatic test_resume_in_hangover();
        wait_drained();
        write_reg(CFG_HANGOVER_ALT, 16'h0002);
        write_reg(CFG_LANGUAGE_MODE, 16'h0001);
        write_reg(CFG_RESUME_FRAMES, 16'h0002);
        send_frame(16'h0000);
        send_frame(16'hFFFF);
        send_frame(16'hFFFF);
        send_frame(16'h0000);
        send_frame(16'h0000);
    endtask

    // random short settings, each followed by talk and silence runs
    task automatic test_random_sessions();
        logic [PROB_BITS-1:0] thr;
        for (int s = 0; s < 5; s++)
        begin
            wait_drained();
            case ($urandom_range(4))
                0:       thr = '0;
                1:       thr = PROB_BITS'($urandom);
                default: thr = PROB_BITS'($urandom_range(58000, 6000));
            endcase
            write_reg(CFG_VOTE_THRESHOLD, thr);
            write_reg(CFG_ONSET_FRAMES, {8'($urandom), 8'($urandom_range(6, 0))});
            write_reg(CFG_WARMUP_FRAMES, {8'($urandom), 8'($urandom_range(12, 0))});
            write_reg(CFG_HANGOVER_FRAMES, {6'($urandom), 10'($urandom_range(12, 0))});
            write_reg(CFG_HANGOVER_ALT, {6'($urandom), 10'($urandom_range(12, 0))});
            write_reg(CFG_RESUME_FRAMES, {8'($urandom), 8'($urandom_range(5, 0))});
            write_reg(CFG_LANGUAGE_MODE, {15'($urandom), 1'($urandom_range(1))});
            write_reg(CFG_UNUSED_INDEX, 16'($urandom));
            send_bursts(24, 8);
        end
    endtask

    // largest warmup, hangover and resume: vote counter saturates, long end
    task automatic test_long_hangover();
        wait_drained();
        write_reg(CFG_VOTE_THRESHOLD, '0);
        write_reg(CFG_WARMUP_FRAMES, 16'd255);
        write_reg(CFG_ONSET_FRAMES, 16'd1);
        write_reg(CFG_HANGOVER_FRAMES, 16'd1023);
        write_reg(CFG_HANGOVER_ALT, 16'd1023);
        write_reg(CFG_RESUME_FRAMES, 16'd255);
        write_reg(CFG_LANGUAGE_MODE, 16'd1);
        // no idling on either side through the warmup
        idle_pct = 0;
        repeat (260) send_frame(speech_prob());
        idle_pct = IDLE_PCT;
        // mostly silence with isolated talk frames until hangover runs out
        for (int k = 0; k < 1060; k++)
            send_frame(($urandom_range(49) == 0) ? speech_prob() : silence_prob());
    endtask

    // highest threshold never votes; then the longest onset run
    task automatic test_long_onset();
        wait_drained();
        write_reg(CFG_VOTE_THRESHOLD, '1);
        write_reg(CFG_WARMUP_FRAMES, 16'd1);
        write_reg(CFG_ONSET_FRAMES, 16'd255);
        write_reg(CFG_HANGOVER_FRAMES, 16'd4);
        write_reg(CFG_LANGUAGE_MODE, 16'd0);
        send_frame(16'hFFFF);
        repeat (19) send_frame(PROB_BITS'($urandom));
        wait_drained();
        write_reg(CFG_VOTE_THRESHOLD, PROB_BITS'($urandom_range(50000, 1000)));
        repeat (260) send_frame(speech_prob());
        send_bursts(30, 8);
    endtask

    // receiver holds off while frames keep coming, then sender waits for drain
    task automatic test_backpressure();
        wait_drained();
        write_reg(CFG_VOTE_THRESHOLD, 16'h8000);
        write_reg(CFG_ONSET_FRAMES, 16'd2);
        write_reg(CFG_WARMUP_FRAMES, 16'd0);
        write_reg(CFG_HANGOVER_FRAMES, 16'd3);
        write_reg(CFG_RESUME_FRAMES, 16'd2);
        hold_cycles = 40;
        send_bursts(40, 5);
        wait_drained();
        send_bursts(40, 5);
    endtask

    // result receiver: random idling, or one long hold-off on request
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (hold_cycles) @(negedge clk);
                hold_cycles = 0;
            end
            else
                res_ch.ready <= rst_n && ($urandom_range(99) >= idle_pct);
        end
    end

    // compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin : check_results
        vds_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_decisions.size() == 0)
                report_mismatch("result item with no frame outstanding");
            else
            begin
                want = pending_decisions.pop_front();
                check_field("speech_active", 32'(res_ch.speech_active),
                            32'(want.speech_active));
                check_field("frame_vote", 32'(res_ch.frame_vote), 32'(want.frame_vote));
                check_field("start_event", 32'(res_ch.start_event),
                            32'(want.start_event));
                check_field("start_frame", res_ch.start_frame, want.start_frame);
                check_field("end_event", 32'(res_ch.end_event), 32'(want.end_event));
                check_field("end_frame", res_ch.end_frame, want.end_frame);
                if (want.start_event)
                    starts_seen++;
                if (want.end_event)
                    ends_seen++;
                results_checked++;
            end
        end
    end

    // main sequence
    initial
    begin
        prob_ch.valid = 1'b0;
        prob_ch.speech_probability = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        cfg_shadow.vote_threshold = VOTE_THRESHOLD_RST;
        cfg_shadow.onset_frames = ONSET_FRAMES_RST;
        cfg_shadow.warmup_frames = WARMUP_FRAMES_RST;
        cfg_shadow.hangover_frames = HANGOVER_FRAMES_RST;
        cfg_shadow.hangover_frames_alt = HANGOVER_ALT_RST;
        cfg_shadow.resume_frames = RESUME_FRAMES_RST;
        cfg_shadow.language_mode = 1'b0;
        frame_no = '0;
        votes_seen = '0;
        in_speech = 1'b0;
        in_hangover = 1'b0;
        silence_run = '0;
        resume_run = '0;
        onset_run = '0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_threshold_edges();
        test_zero_lengths();
        test_resume_in_hangover();
        test_random_sessions();
        test_long_hangover();
        test_long_onset();
        test_backpressure();

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (pending_decisions.size() != 0)
            report_mismatch($sformatf("%0d predicted results never arrived",
                                      pending_decisions.size()));
        $display("sent %0d frames, checked %0d results, %0d register writes",
                 frames_sent, results_checked, reg_writes);
        $display("saw %0d speech starts and %0d speech ends, %0d mismatches",
                 starts_seen, ends_seen, error_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/vds_pkg.sv
rtl/core/vds_ifs.sv
rtl/core/vds_cfg_regs.sv
rtl/core/vds_decision.sv
rtl/core/vad_decision_smoother_top.sv
dv/testbench.sv
